### src/vsa_pkg.sv
// Shared constants, types and codes for the voxel statistics accumulator.
// No dependencies; every other file uses it through scoped names.
package vsa_pkg;

   // Grid geometry
   localparam int GRID_X = 32;
   localparam int GRID_Y = 32;
   localparam int GRID_Z = 8;
   localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
   localparam int DEPTH  = 8192;
   localparam int VID_W  = 13;

   // Field widths
   localparam int COORD_W = 24;
   localparam int LEAF_W  = 16;
   localparam int CNT_W   = 16;
   localparam int SUM_W   = 32;
   localparam int MOM_W   = 48;
   localparam int PROD_W  = 2 * LEAF_W;
   localparam int CELL_W  = COORD_W + 1;
   localparam int IDX_W   = COORD_W + 2;
   localparam int LIN_W   = 32;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_OUTSIDE = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_LEAF_X   = 3'd0,
      CSR_LEAF_Y   = 3'd1,
      CSR_LEAF_Z   = 3'd2,
      CSR_ORIGIN_X = 3'd3,
      CSR_ORIGIN_Y = 3'd4,
      CSR_ORIGIN_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LEAF_W-1:0]  leaf_x;
      logic [LEAF_W-1:0]  leaf_y;
      logic [LEAF_W-1:0]  leaf_z;
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0] origin_z;
   } cfg_type;

   // Classified command passed from front end to back end
   typedef struct packed {
      logic              is_read;
      status_type        status;
      logic [VID_W-1:0]  vid;
      logic [LEAF_W-1:0] off_x;
      logic [LEAF_W-1:0] off_y;
      logic [LEAF_W-1:0] off_z;
   } cmd_type;

endpackage

### src/vsa_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on vsa_pkg for field widths.
interface vsa_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic signed [vsa_pkg::COORD_W-1:0]  point_x;
   logic signed [vsa_pkg::COORD_W-1:0]  point_y;
   logic signed [vsa_pkg::COORD_W-1:0]  point_z;
   logic [vsa_pkg::VID_W-1:0]           read_index;

   modport source (output valid, req_type, point_x, point_y, point_z, read_index,
                   input ready);
   modport sink   (input valid, req_type, point_x, point_y, point_z, read_index,
                   output ready);
endinterface

interface vsa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [vsa_pkg::VID_W-1:0]    voxel_index;
   logic [vsa_pkg::CNT_W-1:0]    point_count;
   logic [vsa_pkg::SUM_W-1:0]    sum_x;
   logic [vsa_pkg::SUM_W-1:0]    sum_y;
   logic [vsa_pkg::SUM_W-1:0]    sum_z;
   logic [vsa_pkg::MOM_W-1:0]    moment_xx;
   logic [vsa_pkg::MOM_W-1:0]    moment_xy;
   logic [vsa_pkg::MOM_W-1:0]    moment_xz;
   logic [vsa_pkg::MOM_W-1:0]    moment_yy;
   logic [vsa_pkg::MOM_W-1:0]    moment_yz;
   logic [vsa_pkg::MOM_W-1:0]    moment_zz;

   modport source (output valid, status, voxel_index, point_count, sum_x, sum_y, sum_z,
                   moment_xx, moment_xy, moment_xz, moment_yy, moment_yz, moment_zz,
                   input ready);
   modport sink   (input valid, status, voxel_index, point_count, sum_x, sum_y, sum_z,
                   moment_xx, moment_xy, moment_xz, moment_yy, moment_yz, moment_zz,
                   output ready);
endinterface

### src/vsa_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vsa_pkg for widths.
module vsa_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vsa_pkg::COORD_W-1:0] dividend,
   input  logic [vsa_pkg::LEAF_W-1:0]  divisor,
   output logic [vsa_pkg::COORD_W-1:0] quotient,
   output logic [vsa_pkg::LEAF_W-1:0]  remainder,
   output logic                        done
);
   localparam int CW = $clog2(vsa_pkg::COORD_W + 1);

   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic [vsa_pkg::COORD_W-1:0]   q_ff, q_in;
   logic [vsa_pkg::LEAF_W-1:0]    rem_ff, rem_in;
   logic [vsa_pkg::LEAF_W-1:0]    div_ff, div_in;
   logic [vsa_pkg::LEAF_W:0]      rem_sh;
   logic                          ge;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[vsa_pkg::COORD_W-1]};
      ge      = rem_sh >= {1'b0, div_ff};
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         cnt_in = CW'(vsa_pkg::COORD_W);
         q_in   = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         q_in   = {q_ff[vsa_pkg::COORD_W-2:0], ge};
         rem_in = ge ? vsa_pkg::LEAF_W'(rem_sh - {1'b0, div_ff})
                     : vsa_pkg::LEAF_W'(rem_sh);
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = q_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;
endmodule

### src/vsa_front.sv
// Front end: accepts requests, divides coordinates by the leaf sizes and
// classifies each item into a command. Depends on vsa_pkg, vsa_if, vsa_div.
module vsa_front (
   input  logic               clock,
   input  logic               reset,
   input  vsa_pkg::cfg_type   cfg,
   vsa_req_if.sink            req_chan,
   output logic               push_valid,
   input  logic               push_ready,
   output vsa_pkg::cmd_type   push_cmd
);
   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_type;

   localparam int LIM [3] = '{vsa_pkg::GRID_X, vsa_pkg::GRID_Y, vsa_pkg::GRID_Z};

   fstate_type                    state_ff, state_in;
   vsa_pkg::cmd_type              cmd_ff, cmd_in;
   logic [2:0]                    neg_ff, neg_in;

   logic                          accept, start;
   logic [vsa_pkg::COORD_W-1:0]   pt   [3];
   logic [vsa_pkg::COORD_W-1:0]   mag  [3];
   logic [vsa_pkg::LEAF_W-1:0]    leaf [3];
   logic [vsa_pkg::COORD_W-1:0]   org  [3];
   logic [vsa_pkg::COORD_W-1:0]   quo  [3];
   logic [vsa_pkg::LEAF_W-1:0]    rem  [3];
   logic [2:0]                    done;
   logic [vsa_pkg::CELL_W-1:0]    col  [3];
   logic [vsa_pkg::IDX_W-1:0]     idx  [3];
   logic [vsa_pkg::LEAF_W-1:0]    off  [3];
   logic [2:0]                    in_rng;
   logic [vsa_pkg::LIN_W-1:0]     lin;

   assign pt[0] = req_chan.point_x;
   assign pt[1] = req_chan.point_y;
   assign pt[2] = req_chan.point_z;
   assign leaf[0] = (cfg.leaf_x == '0) ? vsa_pkg::LEAF_W'(1) : cfg.leaf_x;
   assign leaf[1] = (cfg.leaf_y == '0) ? vsa_pkg::LEAF_W'(1) : cfg.leaf_y;
   assign leaf[2] = (cfg.leaf_z == '0) ? vsa_pkg::LEAF_W'(1) : cfg.leaf_z;
   assign org[0] = cfg.origin_x;
   assign org[1] = cfg.origin_y;
   assign org[2] = cfg.origin_z;

   assign req_chan.ready = (state_ff == F_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign start  = accept && !req_chan.req_type;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      // divide the magnitude, fix up sign afterwards for floor semantics
      assign mag[a] = pt[a][vsa_pkg::COORD_W-1] ? vsa_pkg::COORD_W'(0) - pt[a] : pt[a];

      vsa_div u_div (
         .clock     (clock),
         .reset     (reset),
         .start     (start),
         .dividend  (mag[a]),
         .divisor   (leaf[a]),
         .quotient  (quo[a]),
         .remainder (rem[a]),
         .done      (done[a])
      );

      always_comb begin
         if (neg_ff[a]) begin
            col[a] = vsa_pkg::CELL_W'(0) - vsa_pkg::CELL_W'(quo[a])
                     - vsa_pkg::CELL_W'(rem[a] != '0);
            off[a] = (rem[a] != '0) ? leaf[a] - rem[a] : rem[a];
         end else begin
            col[a] = vsa_pkg::CELL_W'(quo[a]);
            off[a] = rem[a];
         end
         idx[a] = {col[a][vsa_pkg::CELL_W-1], col[a]}
                - {{2{org[a][vsa_pkg::COORD_W-1]}}, org[a]};
         in_rng[a] = !idx[a][vsa_pkg::IDX_W-1] && (idx[a] < vsa_pkg::IDX_W'(LIM[a]));
      end
   end

   assign lin = vsa_pkg::LIN_W'(idx[0])
              + vsa_pkg::LIN_W'(idx[1]) * vsa_pkg::LIN_W'(vsa_pkg::GRID_X)
              + vsa_pkg::LIN_W'(idx[2])
                * vsa_pkg::LIN_W'(vsa_pkg::GRID_X * vsa_pkg::GRID_Y);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      neg_in   = neg_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_chan.req_type) begin
                  cmd_in.is_read = 1'b1;
                  cmd_in.vid     = req_chan.read_index;
                  cmd_in.status  = (vsa_pkg::LIN_W'(req_chan.read_index)
                                    < vsa_pkg::LIN_W'(vsa_pkg::CELLS))
                                   ? vsa_pkg::ST_OK : vsa_pkg::ST_OUTSIDE;
                  cmd_in.off_x   = '0;
                  cmd_in.off_y   = '0;
                  cmd_in.off_z   = '0;
                  state_in       = F_PUSH;
               end else begin
                  neg_in   = {pt[2][vsa_pkg::COORD_W-1], pt[1][vsa_pkg::COORD_W-1],
                              pt[0][vsa_pkg::COORD_W-1]};
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            if (&done) begin
               cmd_in.is_read = 1'b0;
               cmd_in.off_x   = off[0];
               cmd_in.off_y   = off[1];
               cmd_in.off_z   = off[2];
               if ((&in_rng) && (lin < vsa_pkg::LIN_W'(vsa_pkg::DEPTH))) begin
                  cmd_in.status = vsa_pkg::ST_OK;
                  cmd_in.vid    = lin[vsa_pkg::VID_W-1:0];
               end else begin
                  cmd_in.status = vsa_pkg::ST_OUTSIDE;
                  cmd_in.vid    = '0;
               end
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      neg_ff <= neg_in;
   end

   assign push_valid = (state_ff == F_PUSH);
   assign push_cmd   = cmd_ff;
endmodule

### src/vsa_queue.sv
// Small FIFO of classified commands between front and back end.
// Depends on vsa_pkg.
module vsa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  vsa_pkg::cmd_type   push_cmd,
   output logic               pop_valid,
   input  logic               pop_ready,
   output vsa_pkg::cmd_type   pop_cmd
);
   localparam int PW = (vsa_pkg::QUEUE_DEPTH > 1) ? $clog2(vsa_pkg::QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(vsa_pkg::QUEUE_DEPTH + 1);

   vsa_pkg::cmd_type  slot_ff [vsa_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0]     num_ff, num_in;
   logic              do_push, do_pop;

   assign push_ready = (num_ff != NW'(vsa_pkg::QUEUE_DEPTH));
   assign pop_valid  = (num_ff != '0);
   assign pop_cmd    = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      num_in = num_ff;
      if (do_push) wr_in = (wr_ff == PW'(vsa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PW'(vsa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) num_in = num_ff + 1'b1;
      else if (!do_push && do_pop) num_in = num_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         num_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         num_ff <= num_in;
      end
      if (do_push) slot_ff[wr_ff] <= push_cmd;
   end
endmodule

### src/vsa_back.sv
// Back end: voxel memories, read-modify-write of statistics and the
// response register. Depends on vsa_pkg and vsa_if.
module vsa_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  vsa_pkg::cmd_type   pop_cmd,
   vsa_rsp_if.source          rsp_chan
);
   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_DONE} bstate_type;

   localparam int SW = 3 * vsa_pkg::SUM_W;
   localparam int MW = 6 * vsa_pkg::MOM_W;

   // memories
   logic                            touched_mem [vsa_pkg::DEPTH];
   logic [vsa_pkg::CNT_W-1:0]       count_mem   [vsa_pkg::DEPTH];
   logic [SW-1:0]                   sums_mem    [vsa_pkg::DEPTH];
   logic [MW-1:0]                   mom_mem     [vsa_pkg::DEPTH];

   bstate_type                      state_ff, state_in;
   logic [vsa_pkg::VID_W-1:0]       clr_ff, clr_in;
   vsa_pkg::cmd_type                cmd_ff;

   logic                            touched_rd_ff;
   logic [vsa_pkg::CNT_W-1:0]       count_rd_ff;
   logic [2:0][vsa_pkg::SUM_W-1:0]  sums_rd_ff;
   logic [5:0][vsa_pkg::MOM_W-1:0]  mom_rd_ff;
   logic [5:0][vsa_pkg::PROD_W-1:0] prod_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_status_ff;
   logic [vsa_pkg::VID_W-1:0]       rsp_vid_ff;
   logic [vsa_pkg::CNT_W-1:0]       rsp_count_ff;
   logic [2:0][vsa_pkg::SUM_W-1:0]  rsp_sums_ff;
   logic [5:0][vsa_pkg::MOM_W-1:0]  rsp_mom_ff;

   logic                            take, load, commit;
   logic                            touch_we;
   logic [vsa_pkg::VID_W-1:0]       touch_addr;
   logic                            full;
   logic [vsa_pkg::CNT_W-1:0]       base_cnt, new_cnt, out_cnt;
   logic [2:0][vsa_pkg::SUM_W-1:0]  base_sums, new_sums, out_sums;
   logic [5:0][vsa_pkg::MOM_W-1:0]  base_mom, new_mom, out_mom;
   logic [2:0][vsa_pkg::LEAF_W-1:0] offs;
   vsa_pkg::status_type             out_status;

   assign pop_ready = (state_ff == B_IDLE);
   assign take      = pop_valid && pop_ready;
   assign load      = (state_ff == B_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign offs      = {cmd_ff.off_z, cmd_ff.off_y, cmd_ff.off_x};

   always_comb begin
      // untouched voxel starts with identity diagonal
      base_cnt  = touched_rd_ff ? count_rd_ff : '0;
      base_sums = touched_rd_ff ? sums_rd_ff  : '0;
      base_mom  = touched_rd_ff ? mom_rd_ff
                : {vsa_pkg::MOM_W'(1), vsa_pkg::MOM_W'(0), vsa_pkg::MOM_W'(1),
                   vsa_pkg::MOM_W'(0), vsa_pkg::MOM_W'(0), vsa_pkg::MOM_W'(1)};
      full      = (base_cnt == vsa_pkg::COUNT_MAX);
      new_cnt   = base_cnt + 1'b1;
      for (int a = 0; a < 3; a++) begin
         new_sums[a] = base_sums[a] + vsa_pkg::SUM_W'(offs[a]);
      end
      for (int k = 0; k < 6; k++) begin
         new_mom[k] = base_mom[k] + vsa_pkg::MOM_W'(prod_ff[k]);
      end

      out_status = cmd_ff.status;
      out_cnt    = '0;
      out_sums   = '0;
      out_mom    = '0;
      commit     = 1'b0;
      if (cmd_ff.status == vsa_pkg::ST_OK) begin
         if (cmd_ff.is_read) begin
            if (touched_rd_ff) begin
               out_cnt  = count_rd_ff;
               out_sums = sums_rd_ff;
               out_mom  = mom_rd_ff;
            end
         end else if (full) begin
            out_status = vsa_pkg::ST_FULL;
            out_cnt    = base_cnt;
            out_sums   = base_sums;
            out_mom    = base_mom;
         end else begin
            out_cnt  = new_cnt;
            out_sums = new_sums;
            out_mom  = new_mom;
            commit   = load;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == vsa_pkg::VID_W'(vsa_pkg::DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE: if (take) state_in = B_READ;
         B_READ: state_in = B_DONE;
         B_DONE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) cmd_ff <= pop_cmd;
      if (state_ff == B_READ) begin
         prod_ff[0] <= cmd_ff.off_x * cmd_ff.off_x;
         prod_ff[1] <= cmd_ff.off_x * cmd_ff.off_y;
         prod_ff[2] <= cmd_ff.off_x * cmd_ff.off_z;
         prod_ff[3] <= cmd_ff.off_y * cmd_ff.off_y;
         prod_ff[4] <= cmd_ff.off_y * cmd_ff.off_z;
         prod_ff[5] <= cmd_ff.off_z * cmd_ff.off_z;
      end
      if (load) begin
         rsp_status_ff <= out_status;
         rsp_vid_ff    <= cmd_ff.vid;
         rsp_count_ff  <= out_cnt;
         rsp_sums_ff   <= out_sums;
         rsp_mom_ff    <= out_mom;
      end
   end

   // touched flags: cleared by a sweep after reset, set on first accumulate
   assign touch_we   = (state_ff == B_CLEAR) || commit;
   assign touch_addr = (state_ff == B_CLEAR) ? clr_ff : cmd_ff.vid;

   always_ff @(posedge clock) begin
      if (touch_we) touched_mem[touch_addr] <= (state_ff != B_CLEAR);
      if (take) touched_rd_ff <= touched_mem[pop_cmd.vid];
   end

   always_ff @(posedge clock) begin
      if (commit) count_mem[cmd_ff.vid] <= new_cnt;
      if (take) count_rd_ff <= count_mem[pop_cmd.vid];
   end

   always_ff @(posedge clock) begin
      if (commit) sums_mem[cmd_ff.vid] <= new_sums;
      if (take) sums_rd_ff <= sums_mem[pop_cmd.vid];
   end

   always_ff @(posedge clock) begin
      if (commit) mom_mem[cmd_ff.vid] <= new_mom;
      if (take) mom_rd_ff <= mom_mem[pop_cmd.vid];
   end

   // moment lanes: 0 xx, 1 xy, 2 xz, 3 yy, 4 yz, 5 zz
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.voxel_index = rsp_vid_ff;
   assign rsp_chan.point_count = rsp_count_ff;
   assign rsp_chan.sum_x       = rsp_sums_ff[0];
   assign rsp_chan.sum_y       = rsp_sums_ff[1];
   assign rsp_chan.sum_z       = rsp_sums_ff[2];
   assign rsp_chan.moment_xx   = rsp_mom_ff[0];
   assign rsp_chan.moment_xy   = rsp_mom_ff[1];
   assign rsp_chan.moment_xz   = rsp_mom_ff[2];
   assign rsp_chan.moment_yy   = rsp_mom_ff[3];
   assign rsp_chan.moment_yz   = rsp_mom_ff[4];
   assign rsp_chan.moment_zz   = rsp_mom_ff[5];
endmodule

### src/voxel_stats_accumulator_unit.sv
// Top level of the voxel statistics accumulator: configuration registers,
// front end, command queue and back end. Depends on vsa_pkg, vsa_if and submodules.
//
// Each request gives exactly one response. An accumulate request (req_type 0)
// maps the point to a voxel by floor division of each coordinate by its leaf
// size, subtracts the grid origin and adds the point's offset from the voxel
// corner into that voxel's count, offset sums and second moments; the first
// point of a voxel starts the diagonal moments at one. A read request
// (req_type 1) returns the stored statistics of read_index, all zero for a
// voxel never touched. Status 1 flags a point or index outside the grid,
// status 2 a voxel whose count is at its maximum (the point is refused).
// Flow: an accumulate runs the three 24-step bit-serial dividers side by
// side in the front end; a read skips them. The back end reads the voxel
// memories, then writes them back (states B_READ and B_DONE), and takes the next
// command only once the last one is loaded into the response register. A 2-entry queue
// between the two halves and the response register let each side stall on
// its own. After reset the back end sweeps the touched flags before the
// first response; requests are still taken into the queue and
// configuration writes are taken at any time.
module voxel_stats_accumulator_unit (
   input  logic                         clock,
   input  logic                         reset,
   vsa_req_if.sink                      req_chan,
   vsa_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [2:0]                   csr_index,
   input  logic [vsa_pkg::COORD_W-1:0]  csr_wdata
);
   vsa_pkg::cfg_type  cfg_ff, cfg_in;

   logic              push_valid, push_ready;
   vsa_pkg::cmd_type  push_cmd;
   logic              pop_valid, pop_ready;
   vsa_pkg::cmd_type  pop_cmd;

   // register writes; indexes beyond the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (vsa_pkg::csr_index_type'(csr_index))
            vsa_pkg::CSR_LEAF_X:   cfg_in.leaf_x   = csr_wdata[vsa_pkg::LEAF_W-1:0];
            vsa_pkg::CSR_LEAF_Y:   cfg_in.leaf_y   = csr_wdata[vsa_pkg::LEAF_W-1:0];
            vsa_pkg::CSR_LEAF_Z:   cfg_in.leaf_z   = csr_wdata[vsa_pkg::LEAF_W-1:0];
            vsa_pkg::CSR_ORIGIN_X: cfg_in.origin_x = csr_wdata;
            vsa_pkg::CSR_ORIGIN_Y: cfg_in.origin_y = csr_wdata;
            vsa_pkg::CSR_ORIGIN_Z: cfg_in.origin_z = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leaf_x   <= vsa_pkg::LEAF_W'(1000);
         cfg_ff.leaf_y   <= vsa_pkg::LEAF_W'(1000);
         cfg_ff.leaf_z   <= vsa_pkg::LEAF_W'(1000);
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: divide and classify
   vsa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // decoupling queue
   vsa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // back end: memories and response register
   vsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_chan  (rsp_chan)
   );
endmodule

### src/vsa_checker.sv
// Port-level checks for the voxel statistics accumulator, bound to the top.
// Depends on vsa_pkg and voxel_stats_accumulator_unit.
module vsa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic [vsa_pkg::CNT_W-1:0]   rsp_count,
   input logic [vsa_pkg::VID_W-1:0]   rsp_vid
);
   // a transfer that is offered stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == vsa_pkg::ST_OK || rsp_status == vsa_pkg::ST_OUTSIDE
                     || rsp_status == vsa_pkg::ST_FULL))
      else $error("undefined status code");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == vsa_pkg::ST_OUTSIDE |-> rsp_count == '0)
      else $error("outside response carries statistics");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == vsa_pkg::ST_FULL
      |-> rsp_count == vsa_pkg::COUNT_MAX && rsp_vid < vsa_pkg::VID_W'(vsa_pkg::DEPTH - 1)
          || rsp_count == vsa_pkg::COUNT_MAX)
      else $error("refused point on a voxel that is not full");
endmodule

bind voxel_stats_accumulator_unit vsa_checker u_vsa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_count  (rsp_chan.point_count),
   .rsp_vid    (rsp_chan.voxel_index)
);
